FILE: sv/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, switched off while reset is low
`define RCEF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define RCEF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/rcef_pkg.sv
package rcef_pkg;

	typedef logic [7:0] chan_t;

	// effect codes held in the mode register
	typedef enum logic [3:0] {
		MODE_PASS       = 4'd0,
		MODE_BLUE       = 4'd1,
		MODE_GREEN      = 4'd2,
		MODE_RED        = 4'd3,
		MODE_GRAY       = 4'd4,
		MODE_SEPIA      = 4'd5,
		MODE_NEGATIVE   = 4'd6,
		MODE_CYAN_WHITE = 4'd7,
		MODE_CYAN_BLACK = 4'd8,
		MODE_CYAN_RED   = 4'd9
	} mode_t;

	localparam int unsigned CHAN_MAX     = 255;
	localparam int unsigned SHADOW_LIMIT = 150;

	// sepia matrix, unsigned q0.16, row per output channel, column per input channel
	localparam int unsigned SEPIA_FRAC = 16;
	localparam logic [15:0] SEPIA_K [3][3] = '{
		'{16'd25756, 16'd50397, 16'd12386},
		'{16'd22872, 16'd44958, 16'd11010},
		'{16'd17826, 16'd34996, 16'd8585}
	};

	// divide by three for values up to 765: (x * 43691) >> 17 is exact
	localparam logic [15:0] RECIP3       = 16'd43691;
	localparam int unsigned RECIP3_SHIFT = 17;

endpackage

FILE: sv/rcef_if.sv
// input pixel channel
interface rcef_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;

	modport source (output valid, output in_red, output in_green, output in_blue, input ready);
	modport sink (input valid, input in_red, input in_green, input in_blue, output ready);
endinterface

// filtered pixel channel
interface rcef_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;

	modport source (output valid, output out_red, output out_green, output out_blue, input ready);
	modport sink (input valid, input out_red, input out_green, input out_blue, output ready);
endinterface

FILE: sv/rgb_color_effect_filter_top.sv
// rgb colour effect filter
// pix carries one 8-bit rgb pixel per beat (valid/ready), fx returns the
// filtered pixel, one beat out for every beat in, in the same order.
// filter_mode_we/filter_mode_data load the 4-bit effect code; write it only
// while no pixel is in flight. codes 10..15 behave as pass-through.
// a beat accepted on pix is held in the stage 1, stage 2 and stage 3
// registers in turn and is offered on fx from the stage 3 register:
//   stage 1: sepia products and channel sum
//   stage 2: sepia sums with clamp, average and inverted average (x/3 by
//            reciprocal multiply)
//   stage 3: effect select, held in the output register
// throughput: one pixel per cycle for as long as fx takes beats.
// each stage has its own valid bit and moves on when the stage after it is
// empty or moving, so bubbles close up; while fx stalls, the three stages
// fill and pix.ready then drops, and nothing is lost or repeated.
// reset (arst_n low) empties the pipeline and sets the mode to pass-through.
module rgb_color_effect_filter_top
	import rcef_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       filter_mode_we,
	input  logic [3:0] filter_mode_data,
	rcef_in_if.sink    pix,
	rcef_out_if.source fx
);

	logic [3:0] filter_mode_q;

	logic        v_s1;
	logic [3:0]  mode_s1;
	chan_t       rgb_s1 [3];
	logic [9:0]  sum_s1;
	logic [23:0] prod_s1 [3][3];

	logic       v_s2;
	logic [3:0] mode_s2;
	chan_t      rgb_s2 [3];
	chan_t      avg_s2;
	chan_t      inv_s2;
	chan_t      sep_s2 [3];

	logic  v_s3;
	chan_t res_s3 [3];

	logic  adv1, adv2, adv3;
	chan_t pix_rgb [3];
	logic [24:0] sep_sum [3];
	logic [8:0]  sep_int [3];
	logic [25:0] avg_prod, inv_prod;
	logic [9:0]  inv_sum;
	chan_t sel [3];

	// stage hand-over: a stage loads when it is empty or its content moves on
	assign adv3      = !v_s3 || fx.ready;
	assign adv2      = !v_s2 || adv3;
	assign adv1      = !v_s1 || adv2;
	assign pix.ready = adv1;

	assign pix_rgb[0] = pix.in_red;
	assign pix_rgb[1] = pix.in_green;
	assign pix_rgb[2] = pix.in_blue;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_mode_q <= MODE_PASS;
		end else if (filter_mode_we) begin
			filter_mode_q <= filter_mode_data;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= pix.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	// stage 1: products and channel sum
	always_ff @(posedge clk) begin
		if (adv1) begin
			mode_s1 <= filter_mode_q;
			sum_s1  <= 10'(pix.in_red) + 10'(pix.in_green) + 10'(pix.in_blue);
			for (int i = 0; i < 3; i++) begin
				rgb_s1[i] <= pix_rgb[i];
				for (int j = 0; j < 3; j++) begin
					prod_s1[i][j] <= 24'(pix_rgb[j]) * 24'(SEPIA_K[i][j]);
				end
			end
		end
	end

	// stage 2 logic: sepia sums with clamp, average and inverted average
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sep_sum[i] = 25'(prod_s1[i][0]) + 25'(prod_s1[i][1]) + 25'(prod_s1[i][2]);
			sep_int[i] = sep_sum[i][SEPIA_FRAC +: 9];
		end
		inv_sum  = 10'(3 * CHAN_MAX) - sum_s1;
		avg_prod = 26'(sum_s1) * 26'(RECIP3);
		inv_prod = 26'(inv_sum) * 26'(RECIP3);
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			mode_s2 <= mode_s1;
			rgb_s2  <= rgb_s1;
			avg_s2  <= avg_prod[RECIP3_SHIFT +: 8];
			inv_s2  <= inv_prod[RECIP3_SHIFT +: 8];
			for (int i = 0; i < 3; i++) begin
				sep_s2[i] <= (sep_int[i] > 9'(CHAN_MAX)) ? 8'(CHAN_MAX) : sep_int[i][7:0];
			end
		end
	end

	// stage 3 logic: effect select
	always_comb begin
		sel = rgb_s2;
		unique case (mode_t'(mode_s2))
			MODE_BLUE: begin
				sel[0] = '0;
				sel[1] = '0;
			end
			MODE_GREEN: begin
				sel[0] = '0;
				sel[2] = '0;
			end
			MODE_RED: begin
				sel[1] = '0;
				sel[2] = '0;
			end
			MODE_GRAY: begin
				sel = '{avg_s2, avg_s2, avg_s2};
			end
			MODE_SEPIA: begin
				sel = sep_s2;
			end
			MODE_NEGATIVE: begin
				for (int i = 0; i < 3; i++) sel[i] = ~rgb_s2[i];
			end
			MODE_CYAN_WHITE: begin
				// bright pixels (inverted average up to SHADOW_LIMIT) turn to light grey
				if (inv_s2 <= 8'(SHADOW_LIMIT)) begin
					sel = '{~inv_s2, ~inv_s2, ~inv_s2};
				end else begin
					sel = '{8'd0, inv_s2, inv_s2};
				end
			end
			MODE_CYAN_BLACK: begin
				sel = '{8'd0, inv_s2, inv_s2};
			end
			MODE_CYAN_RED: begin
				sel = '{avg_s2, inv_s2, inv_s2};
			end
			default: begin
				sel = rgb_s2;
			end
		endcase
	end

	// stage 3: output register
	always_ff @(posedge clk) begin
		if (adv3) begin
			res_s3 <= sel;
		end
	end

	assign fx.valid     = v_s3;
	assign fx.out_red   = res_s3[0];
	assign fx.out_green = res_s3[1];
	assign fx.out_blue  = res_s3[2];

endmodule

FILE: sv/rcef_checker.sv
`include "assert_macros.svh"

// port-level checks on the filter
module rcef_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue
);

	// a stalled result beat stays offered
	`RCEF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "fx valid dropped while stalled")

	// a stalled result beat keeps its pixel
	`RCEF_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable({out_red, out_green, out_blue}), "fx pixel changed while stalled")

	// input back-pressure only comes from a stalled, full output
	`RCEF_ASSERT(a_bp_cause, !in_ready |-> out_valid && !out_ready, "pix stalled with no stall on fx")

	// reset empties the pipeline: fx valid stays low while reset is low
	`RCEF_ASSERT_ALWAYS(a_rst_empty, !arst_n |-> !out_valid, "fx valid during reset")

endmodule

bind rgb_color_effect_filter_top rcef_checker u_rcef_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pix.ready),
	.out_valid (fx.valid),
	.out_ready (fx.ready),
	.out_red   (fx.out_red),
	.out_green (fx.out_green),
	.out_blue  (fx.out_blue)
);
